FILE: hdl/frame_receiver_with_checksum_core_macros.svh
// Assertion macros shared by the frame receiver RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef FRAME_RECEIVER_WITH_CHECKSUM_CORE_MACROS_SVH
`define FRAME_RECEIVER_WITH_CHECKSUM_CORE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define FRC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define FRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/frc_pkg.sv
// Package for the frame receiver: checksum constants, register indexes,
// result codes and the result record type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package frc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] SUM_SEED = 8'hB7;
  localparam logic [BYTE_W-1:0] SUM_XOR  = 8'hA4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_FIRST    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_SECOND   = 2'd3;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   out_data;
    logic [BYTE_W-1:0]   frame_number;
    logic [BYTE_W-1:0]   frame_length;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/frame_receiver_with_checksum_core.sv
// Frame receiver core: deframes a byte stream, checks the add-xor checksum
// and end markers. Depends on frc_pkg and the assertion macro header.
// Input channel: in_valid / in_stall with rx_byte, one received byte per
//   request. A request is taken at an edge with in_valid high, in_stall low.
// Output channel: out_valid / out_stall with kind, out_data, frame_number,
//   frame_length, status. Payload bytes come out with kind 0 as they arrive;
//   the second end marker byte yields one kind 1 status result.
//   Start marker, id, length, checksum and first end marker bytes give no result.
// Configuration: cfg_we, cfg_index, cfg_data write the four marker bytes;
//   write only while the block is idle.
// A result is written into the output queue at the edge that takes its input byte.
// Throughput: one byte per cycle while in_stall is low; the per-byte update of frame state and
//   checksum is a single add/xor and compare, done in the accepting cycle.
// Results wait in a two-entry output queue. While the receiver stalls, input
//   bytes keep being taken until both entries hold results; in_stall is then
//   high until one entry drains.
// Reset (rst, synchronous): marker registers clear to zero, the hunt
//   restarts at the first start byte, checksum returns to its seed and the
//   output queue empties.
`timescale 1ns / 1ps
`default_nettype none
`include "frame_receiver_with_checksum_core_macros.svh"

module frame_receiver_with_checksum_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [frc_pkg::BYTE_W-1:0]    cfg_data,
  // input bytes
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [frc_pkg::BYTE_W-1:0]    rx_byte,
  // results
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               kind,
  output logic [frc_pkg::BYTE_W-1:0]         out_data,
  output logic [frc_pkg::BYTE_W-1:0]         frame_number,
  output logic [frc_pkg::BYTE_W-1:0]         frame_length,
  output logic [frc_pkg::STATUS_W-1:0]       status
);

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_ID,
    PH_LEN,
    PH_PAYLOAD,
    PH_CHECK,
    PH_END1,
    PH_END2
  } phase_t;

  // marker registers
  logic [frc_pkg::BYTE_W-1:0] start_first;
  logic [frc_pkg::BYTE_W-1:0] start_second;
  logic [frc_pkg::BYTE_W-1:0] end_first;
  logic [frc_pkg::BYTE_W-1:0] end_second;

  // frame state
  phase_t                     phase, phase_next;
  logic [frc_pkg::BYTE_W-1:0] running_sum, running_sum_next;
  logic [frc_pkg::BYTE_W-1:0] payload_length, payload_length_next;
  logic [frc_pkg::BYTE_W-1:0] bytes_seen, bytes_seen_next;
  logic [frc_pkg::BYTE_W-1:0] frame_id_held, frame_id_held_next;
  logic                       sum_bad, sum_bad_next;
  logic                       end_bad, end_bad_next;

  // output queue
  frc_pkg::result_t queue [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  logic             accept;
  logic             pop;
  logic             push;
  frc_pkg::result_t result;

  assign in_stall  = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_first  <= '0;
      start_second <= '0;
      end_first    <= '0;
      end_second   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        frc_pkg::REG_START_FIRST:  start_first  <= cfg_data;
        frc_pkg::REG_START_SECOND: start_second <= cfg_data;
        frc_pkg::REG_END_FIRST:    end_first    <= cfg_data;
        frc_pkg::REG_END_SECOND:   end_second   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [frc_pkg::BYTE_W-1:0] seen_inc;
    seen_inc            = bytes_seen + 8'd1;
    phase_next          = phase;
    running_sum_next    = running_sum;
    payload_length_next = payload_length;
    bytes_seen_next     = bytes_seen;
    frame_id_held_next  = frame_id_held;
    sum_bad_next        = sum_bad;
    end_bad_next        = end_bad;
    push                = 1'b0;
    result.kind         = frc_pkg::KIND_PAYLOAD;
    result.out_data     = rx_byte;
    result.frame_number = frame_id_held;
    result.frame_length = payload_length;
    result.status       = '0;
    case (phase)
      PH_HUNT1: begin
        if (rx_byte == start_first) phase_next = PH_HUNT2;
      end
      PH_HUNT2: begin
        // a repeated first start byte keeps waiting for the second
        if (rx_byte == start_second) phase_next = PH_ID;
        else if (rx_byte != start_first) phase_next = PH_HUNT1;
      end
      PH_ID: begin
        frame_id_held_next = rx_byte;
        phase_next         = PH_LEN;
      end
      PH_LEN: begin
        payload_length_next = rx_byte;
        bytes_seen_next     = '0;
        running_sum_next    = frc_pkg::SUM_SEED;
        sum_bad_next        = 1'b0;
        end_bad_next        = 1'b0;
        phase_next          = (rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        running_sum_next = (running_sum + rx_byte) ^ frc_pkg::SUM_XOR;
        bytes_seen_next  = seen_inc;
        push             = 1'b1;
        if (seen_inc == payload_length) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        sum_bad_next = (rx_byte != running_sum);
        phase_next   = PH_END1;
      end
      PH_END1: begin
        end_bad_next = (rx_byte != end_first);
        phase_next   = PH_END2;
      end
      default: begin
        push            = 1'b1;
        result.kind     = frc_pkg::KIND_STATUS;
        result.out_data = '0;
        result.status   = {end_bad || (rx_byte != end_second), sum_bad};
        phase_next      = PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT1;
      running_sum    <= frc_pkg::SUM_SEED;
      payload_length <= '0;
      bytes_seen     <= '0;
      frame_id_held  <= '0;
      sum_bad        <= 1'b0;
      end_bad        <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      running_sum    <= running_sum_next;
      payload_length <= payload_length_next;
      bytes_seen     <= bytes_seen_next;
      frame_id_held  <= frame_id_held_next;
      sum_bad        <= sum_bad_next;
      end_bad        <= end_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push) queue[wr_ptr] <= result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (accept && push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, accept && push} - {1'b0, pop};
    end
  end

  assign kind         = queue[rd_ptr].kind;
  assign out_data     = queue[rd_ptr].out_data;
  assign frame_number = queue[rd_ptr].frame_number;
  assign frame_length = queue[rd_ptr].frame_length;
  assign status       = queue[rd_ptr].status;

  `FRC_ASSERT_ALWAYS(a_count_range, clk, rst, count != 2'd3, "output queue overflow")

  `FRC_ASSERT_NEXT(a_status_queued, clk, rst, accept && phase == PH_END2, out_valid, "status result not queued")

  `FRC_ASSERT_NEXT(a_seed_after_len, clk, rst, accept && phase == PH_LEN, running_sum == frc_pkg::SUM_SEED && bytes_seen == '0, "checksum not reseeded")

  `FRC_ASSERT_ALWAYS(a_payload_status, clk, rst, !(out_valid && kind == frc_pkg::KIND_PAYLOAD) || status == '0, "payload result carries status")

endmodule

`default_nettype wire
